// ----- sv/mrfe_pkg.sv -----
// ----------------------------------------------------------------------------
// mrfe_pkg
// Shared types, codes and the CRC-16 helper for the read frame engine.
// ----------------------------------------------------------------------------
package mrfe_pkg;

    localparam int FRAME_BYTES_DEF = 128;

    localparam logic       REQ_START = 1'b0;
    localparam logic       REQ_BYTE  = 1'b1;

    localparam logic [7:0] ADDR_BYTE = 8'hFF;
    localparam logic [7:0] FUNC_READ = 8'h03;
    localparam logic [8:0] HDR_EXTRA = 9'd5;

    typedef enum logic [1:0] {
        KIND_REQ     = 2'd0,
        KIND_REG     = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  start;
        logic  store;
        logic  set_err;
        logic  load;
        t_kind kind;
        logic  pair_clr;
        logic  rd_hi;
        logic  rd_lo;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;
        logic overrun;
        logic short_frame;
        logic too_long;
        logic exact;
        logic pkt_end;
        logic crc_ok;
        logic no_pairs;
        logic pair_last;
        logic tx_last;
        logic out_free;
    } t_sts;

    // One byte of CRC-16/MODBUS (reflected polynomial 0xA001).
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/mrfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrfe_ctrl
// Controller: sequences request transmission, byte checks and the pair walk.
// ----------------------------------------------------------------------------
module mrfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_req_type,
    output logic            o_in_ready,
    input  mrfe_pkg::t_sts  i_sts,
    output mrfe_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_TX, S_EVAL, S_RDHI, S_RDLO, S_PAIR, S_ERR
    } t_state;

    t_state          r_state, n_state;
    mrfe_pkg::t_kind r_ekind, n_ekind;
    logic            w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_ekind = r_ekind;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req_type == mrfe_pkg::REQ_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_TX;
                    end else if (i_sts.err) begin
                        n_state = S_IDLE;
                    end else if (i_sts.overrun) begin
                        o_cmd.set_err = 1'b1;
                        n_ekind       = mrfe_pkg::KIND_LEN_ERR;
                        n_state       = S_ERR;
                    end else begin
                        o_cmd.store = 1'b1;
                        n_state     = S_EVAL;
                    end
                end
            end
            S_TX: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = mrfe_pkg::KIND_REQ;
                    if (i_sts.tx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EVAL: begin
                if (i_sts.short_frame) begin
                    n_state = S_IDLE;
                end else if (i_sts.too_long) begin
                    o_cmd.set_err = 1'b1;
                    n_ekind       = mrfe_pkg::KIND_LEN_ERR;
                    n_state       = S_ERR;
                end else if (i_sts.pkt_end && i_sts.exact) begin
                    if (!i_sts.crc_ok) begin
                        n_ekind = mrfe_pkg::KIND_CRC_ERR;
                        n_state = S_ERR;
                    end else if (i_sts.no_pairs) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.pair_clr = 1'b1;
                        n_state        = S_RDHI;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RDHI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_RDLO;
            end
            S_RDLO: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_PAIR;
            end
            S_PAIR: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = mrfe_pkg::KIND_REG;
                    n_state    = i_sts.pair_last ? S_IDLE : S_RDHI;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.kind = r_ekind;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ekind <= mrfe_pkg::KIND_LEN_ERR;
        end else begin
            r_state <= n_state;
            r_ekind <= n_ekind;
        end
    end

endmodule

// ----- sv/mrfe_dp.sv -----
// ----------------------------------------------------------------------------
// mrfe_dp
// Datapath: frame buffer, running CRC, request bytes and the output register.
// ----------------------------------------------------------------------------
module mrfe_dp #(
    parameter int FRAME_BYTES = mrfe_pkg::FRAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mrfe_pkg::t_cmd  i_cmd,
    output mrfe_pkg::t_sts  o_sts,
    input  logic [15:0]     i_start_register,
    input  logic [15:0]     i_register_count,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_packet_end,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_tx_byte,
    output logic [15:0]     o_reg_address,
    output logic [15:0]     o_reg_value,
    output logic            o_last
);

    localparam int LW = $clog2(FRAME_BYTES);

    logic [7:0]    r_mem [FRAME_BYTES];
    logic [15:0]   r_start, r_count, r_tcrc, r_crc;
    logic [2:0]    r_tidx;
    logic [LW-1:0] r_len;
    logic          r_err, r_pe;
    logic [7:0]    r_b2, r_p1, r_p2, r_rdata, r_hi;
    logic [6:0]    r_pair;
    logic          r_valid, r_last;
    logic [1:0]    r_kind;
    logic [7:0]    r_tx;
    logic [15:0]   r_addr, r_val;

    logic [7:0]    w_txb;
    logic [8:0]    w_len9, w_expect, w_rd9;
    logic [7:0]    w_pairs;
    logic          w_out_free;

    always_comb begin
        case (r_tidx)
            3'd0:    w_txb = mrfe_pkg::ADDR_BYTE;
            3'd1:    w_txb = mrfe_pkg::FUNC_READ;
            3'd2:    w_txb = r_start[15:8];
            3'd3:    w_txb = r_start[7:0];
            3'd4:    w_txb = r_count[15:8];
            3'd5:    w_txb = r_count[7:0];
            3'd6:    w_txb = r_tcrc[7:0];
            default: w_txb = r_tcrc[15:8];
        endcase
    end

    assign w_len9     = 9'(r_len);
    assign w_expect   = {1'b0, r_b2} + mrfe_pkg::HDR_EXTRA;
    assign w_pairs    = {1'b0, r_b2[7:1]};
    assign w_out_free = !r_valid || i_ready;
    // Pair i holds its high byte at 3 + 2i and its low byte one place on.
    assign w_rd9      = 9'd3 + {1'b0, r_pair, 1'b0} + (i_cmd.rd_lo ? 9'd1 : 9'd0);

    always_comb begin
        o_sts.err         = r_err;
        o_sts.overrun     = (r_len >= LW'(FRAME_BYTES - 2));
        o_sts.short_frame = (w_len9 < 9'd3);
        o_sts.too_long    = (w_len9 > w_expect);
        o_sts.exact       = (w_len9 == w_expect);
        o_sts.pkt_end     = r_pe;
        o_sts.crc_ok      = ({r_p1, r_p2} == r_crc);
        o_sts.no_pairs    = (w_pairs == 8'd0);
        o_sts.pair_last   = ({1'b0, r_pair} + 8'd1 == w_pairs);
        o_sts.tx_last     = (r_tidx == 3'd7);
        o_sts.out_free    = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_len] <= i_rx_byte;
        end
        if (i_cmd.rd_hi || i_cmd.rd_lo) begin
            r_rdata <= r_mem[w_rd9[LW-1:0]];
        end
        if (i_cmd.rd_lo) begin
            r_hi <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_err   <= 1'b0;
            r_start <= '0;
            r_tidx  <= '0;
            r_valid <= 1'b0;
            r_crc   <= 16'hFFFF;
        end else begin
            if (i_cmd.start) begin
                r_start <= i_start_register;
                r_count <= i_register_count;
                r_tcrc  <= 16'hFFFF;
                r_tidx  <= '0;
                r_len   <= '0;
                r_err   <= 1'b0;
                r_crc   <= 16'hFFFF;
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.store) begin
                r_len <= r_len + 1'b1;
                r_pe  <= i_packet_end;
                r_p1  <= i_rx_byte;
                r_p2  <= r_p1;
                // The CRC trails the stored bytes by two: the last two are the checksum.
                if (w_len9 >= 9'd2) begin
                    r_crc <= mrfe_pkg::crc_byte(r_crc, r_p2);
                end
                if (w_len9 == 9'd2) begin
                    r_b2 <= i_rx_byte;
                end
            end
            if (i_cmd.pair_clr) begin
                r_pair <= '0;
            end
            if (i_cmd.load) begin
                r_valid <= 1'b1;
                r_kind  <= i_cmd.kind;
                case (i_cmd.kind)
                    mrfe_pkg::KIND_REQ: begin
                        r_tx   <= w_txb;
                        r_addr <= '0;
                        r_val  <= '0;
                        r_last <= (r_tidx == 3'd7);
                        // Only the six header bytes are folded into the checksum.
                        if (r_tidx < 3'd6) begin
                            r_tcrc <= mrfe_pkg::crc_byte(r_tcrc, w_txb);
                        end
                        r_tidx <= r_tidx + 3'd1;
                    end
                    mrfe_pkg::KIND_REG: begin
                        r_tx   <= '0;
                        r_addr <= r_start + {9'd0, r_pair};
                        r_val  <= {r_hi, r_rdata};
                        r_last <= ({1'b0, r_pair} + 8'd1 == w_pairs);
                        r_pair <= r_pair + 7'd1;
                    end
                    default: begin
                        r_tx   <= '0;
                        r_addr <= '0;
                        r_val  <= '0;
                        r_last <= 1'b1;
                    end
                endcase
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx;
    assign o_reg_address = r_addr;
    assign o_reg_value   = r_val;
    assign o_last        = r_last;

endmodule

// ----- sv/modbus_read_frame_engine.sv -----
// ----------------------------------------------------------------------------
// modbus_read_frame_engine
// Master side of a Modbus function-3 read: request framing and response check.
// ----------------------------------------------------------------------------
// A start item produces the eight request bytes, one transfer per cycle when
// the downstream side is ready. A response byte is first stored in the frame
// buffer, folding the running CRC, and is then checked for its length and,
// on a packet end, the checksum. A good frame then walks the buffer through
// its single registered read port, reading the high and then the low byte of
// each register pair, giving one register update per pair. Length and overrun
// faults make the engine ignore further bytes until the next start. Results
// sit in an output register, so the next item is taken while the last result
// still waits.
module modbus_read_frame_engine #(
    parameter int FRAME_BYTES = mrfe_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] start_register, [31:16] register_count, [39:32] rx_byte
    input  logic [39:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte, [23:8] reg_address, [39:24] reg_value
    output logic [39:0] m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    mrfe_pkg::t_cmd w_cmd;
    mrfe_pkg::t_sts w_sts;

    mrfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mrfe_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_start_register (s_axis_tdata[15:0]),
        .i_register_count (s_axis_tdata[31:16]),
        .i_rx_byte        (s_axis_tdata[39:32]),
        .i_packet_end     (s_axis_tlast),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_kind           (m_axis_tuser),
        .o_tx_byte        (m_axis_tdata[7:0]),
        .o_reg_address    (m_axis_tdata[23:8]),
        .o_reg_value      (m_axis_tdata[39:24]),
        .o_last           (m_axis_tlast)
    );

endmodule
